// ===== src/assert_macros.svh =====
// assertion macros used by the checker file elcs_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ELCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("elcs check failed");

// next-cycle implication, disabled while reset is low
`define ELCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("elcs check failed");

`endif

// ===== src/elcs_pkg.sv =====
// shared types, constants and the escape table of the line lexer
// no dependencies
package elcs_pkg;

    // default width of the line counters
    localparam int LINE_NUMBER_BITS_DEF = 24;
    localparam int LINE_OUT_BITS        = 24;

    // configuration port
    localparam int          APB_ADDR_BITS   = 3;
    localparam int          APB_DATA_BITS   = 32;
    localparam logic        REG_FIRST_LINE  = 1'b0;
    localparam logic [23:0] FIRST_LINE_RESET = 24'd1;

    // characters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_P         = 8'h70;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_N         = 8'h6E;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    // result kinds
    typedef enum logic [1:0] {
        KIND_LINE    = 2'd0,
        KIND_COMMENT = 2'd1,
        KIND_EOL     = 2'd2,
        KIND_EOI     = 2'd3
    } t_kind;

    // parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_CONT    = 3'd1,
        MODE_COMLEAD = 3'd2,
        MODE_COMBODY = 3'd3,
        MODE_BSL     = 3'd4,
        MODE_OCT     = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  byte_value;
        logic [23:0] line_number;
        logic        bad_escape;
        logic        truncated_line;
        logic        last_result;
    } t_out_word;

    // results of one item handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        t_out_word  res0;
        t_out_word  res1;
    } t_push;

    // register write toward the lexer
    typedef struct packed {
        logic        wr;
        logic [23:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_esc;

    // single-letter escapes
    function automatic t_esc elcs_escape(input logic [7:0] c);
        t_esc e;
        e.hit   = 1'b1;
        e.value = c;
        case (c)
            CH_B:         e.value = 8'd8;
            CH_BACKSLASH: e.value = CH_BACKSLASH;
            CH_P:         e.value = CH_HASH;
            CH_F:         e.value = 8'd12;
            CH_A:         e.value = 8'd7;
            CH_R:         e.value = 8'd13;
            CH_T:         e.value = 8'd9;
            CH_N:         e.value = 8'd10;
            default:      e.hit = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// ===== src/elcs_stream_if.sv =====
// valid/ready stream channel carrying one word per handshake
// payload type given by parameter
interface elcs_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/escaped_line_comment_splitter_top.sv =====
// a result word is offered once its byte has passed the input register and the result queue
// throughput: one byte per cycle while the queue has room; a byte that ends a short octal escape
//   can yield two words into the three-word queue, which may then hold the input back
// input taken whenever the input register is free or the queue holds <= 1 word
// reset: synchronous active low, parser back to normal, line number to 1
module escaped_line_comment_splitter_top #(
    parameter int LINE_NUMBER_BITS = elcs_pkg::LINE_NUMBER_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    elcs_stream_if.sink                        i_text,
    elcs_stream_if.source                      o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [elcs_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [elcs_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [elcs_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    elcs_pkg::t_cfg_wr   w_cfg;
    elcs_pkg::t_push     w_push;
    elcs_pkg::t_out_word w_word;
    logic                w_room;

    // configuration register
    elcs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // decode and parser state
    elcs_lexer #(
        .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_text.valid),
        .i_word  (i_text.payload),
        .o_ready (i_text.ready),
        .i_room  (w_room),
        .i_cfg   (w_cfg),
        .o_push  (w_push)
    );

    // result queue
    elcs_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_word  (w_word)
    );

    assign o_result.payload = w_word;

endmodule

// ===== src/elcs_apb_regs.sv =====
// apb register block holding first_line_number
// depends on elcs_pkg
module elcs_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [elcs_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [elcs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [elcs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output elcs_pkg::t_cfg_wr                   o_cfg
);

    logic [23:0] r_first_line;
    logic        w_hit;
    logic        w_wr;

    // register index is the word address
    assign w_hit  = (paddr[2] == elcs_pkg::REG_FIRST_LINE);
    assign w_wr   = psel && penable && pwrite && w_hit;
    assign pready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line <= elcs_pkg::FIRST_LINE_RESET;
        end else if (w_wr) begin
            r_first_line <= pwdata[23:0];
        end
    end

    // read data
    assign prdata = w_hit ? elcs_pkg::APB_DATA_BITS'(r_first_line) : '0;

    assign o_cfg.wr    = w_wr;
    assign o_cfg.value = pwdata[23:0];

endmodule

// ===== src/elcs_lexer.sv =====
// input register, escape/comment decode and parser state
// depends on elcs_pkg
module elcs_lexer #(
    parameter int LINE_NUMBER_BITS = elcs_pkg::LINE_NUMBER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  elcs_pkg::t_in_word  i_word,
    output logic                o_ready,
    input  logic                i_room,
    input  elcs_pkg::t_cfg_wr   i_cfg,
    output elcs_pkg::t_push     o_push
);

    localparam int LNB = LINE_NUMBER_BITS;

    logic                  r_in_valid;
    elcs_pkg::t_in_word    r_in;
    elcs_pkg::t_mode       r_mode, n_mode;
    logic [8:0]            r_oct_val, n_oct_val;
    logic [1:0]            r_oct_digits, n_oct_digits;
    logic [LNB-1:0]        r_line_start, n_line_start;
    logic [LNB-1:0]        r_lines_consumed, n_lines_consumed;
    logic                  r_has_bytes, n_has_bytes;

    logic                  w_go;
    logic [LNB+23:0]       w_cfg_ext;
    logic [LNB+23:0]       w_rst_ext;
    logic [LNB+23:0]       w_ls_ext;
    logic [23:0]           w_line_no;
    logic [LNB-1:0]        w_adv;
    logic [LNB-1:0]        w_adv_eol;

    // line counters mapped to and from the fixed 24-bit fields
    assign w_cfg_ext = (LNB+24)'(i_cfg.value);
    assign w_rst_ext = (LNB+24)'(elcs_pkg::FIRST_LINE_RESET);
    assign w_ls_ext  = (LNB+24)'(r_line_start);
    assign w_line_no = w_ls_ext[23:0];
    assign w_adv     = r_line_start + r_lines_consumed;
    assign w_adv_eol = r_line_start + r_lines_consumed + LNB'(1);

    // input register advances when the queue has room for two words
    assign w_go    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_word;
        end
    end

    // decode of one item
    always_comb begin
        elcs_pkg::t_out_word res [2];
        elcs_pkg::t_out_word tmp;
        elcs_pkg::t_mode     mode_eff;
        elcs_pkg::t_esc      esc;
        logic [1:0]          cnt;
        logic [7:0]          c;
        logic                is_oct;
        logic                do_eol;
        logic                done;

        n_mode           = r_mode;
        n_oct_val        = r_oct_val;
        n_oct_digits     = r_oct_digits;
        n_line_start     = r_line_start;
        n_lines_consumed = r_lines_consumed;
        n_has_bytes      = r_has_bytes;

        c        = r_in.text_byte;
        is_oct   = (c >= elcs_pkg::CH_ZERO) && (c <= elcs_pkg::CH_SEVEN);
        esc      = elcs_pkg::elcs_escape(c);
        cnt      = 2'd0;
        do_eol   = 1'b0;
        done     = 1'b0;
        mode_eff = r_mode;

        tmp.result_kind    = elcs_pkg::KIND_LINE;
        tmp.byte_value     = 8'd0;
        tmp.line_number    = w_line_no;
        tmp.bad_escape     = 1'b0;
        tmp.truncated_line = 1'b0;
        tmp.last_result    = 1'b0;
        res[0] = tmp;
        res[1] = tmp;

        if (r_in.end_of_input) begin
            // end of input drops any pending escape or comment
            tmp.result_kind    = elcs_pkg::KIND_EOI;
            tmp.truncated_line = r_has_bytes;
            res[0]           = tmp;
            cnt              = 2'd1;
            n_mode           = elcs_pkg::MODE_NORMAL;
            n_oct_val        = 9'd0;
            n_oct_digits     = 2'd0;
            n_line_start     = w_adv;
            n_lines_consumed = '0;
            n_has_bytes      = 1'b0;
            done             = 1'b1;
        end else if (r_mode == elcs_pkg::MODE_OCT) begin
            if (is_oct) begin
                n_oct_val    = {r_oct_val[5:0], c[2:0]};
                n_oct_digits = r_oct_digits + 2'd1;
                if (n_oct_digits == elcs_pkg::OCT_MAX_DIGITS) begin
                    tmp.byte_value = n_oct_val[7:0];
                    res[0]       = tmp;
                    cnt          = 2'd1;
                    n_has_bytes  = 1'b1;
                    n_mode       = elcs_pkg::MODE_NORMAL;
                    n_oct_val    = 9'd0;
                    n_oct_digits = 2'd0;
                end
                done = 1'b1;
            end else begin
                // octal ended by another byte: flush it first
                tmp.byte_value = r_oct_val[7:0];
                res[0]       = tmp;
                cnt          = 2'd1;
                n_has_bytes  = 1'b1;
                n_mode       = elcs_pkg::MODE_NORMAL;
                n_oct_val    = 9'd0;
                n_oct_digits = 2'd0;
                mode_eff     = elcs_pkg::MODE_NORMAL;
            end
        end

        // main mode handling
        tmp = res[1];
        if (!done) begin
            case (mode_eff)
                elcs_pkg::MODE_CONT: begin
                    if (c == elcs_pkg::CH_NL) begin
                        n_lines_consumed = r_lines_consumed + LNB'(1);
                        n_mode           = elcs_pkg::MODE_NORMAL;
                    end
                end
                elcs_pkg::MODE_COMLEAD: begin
                    if (c == elcs_pkg::CH_NL) begin
                        do_eol = 1'b1;
                    end else if (c != elcs_pkg::CH_SPACE && c != elcs_pkg::CH_TAB) begin
                        n_mode          = elcs_pkg::MODE_COMBODY;
                        tmp.result_kind = elcs_pkg::KIND_COMMENT;
                        tmp.byte_value  = c;
                        res[cnt[0]]     = tmp;
                        cnt             = cnt + 2'd1;
                    end
                end
                elcs_pkg::MODE_COMBODY: begin
                    if (c == elcs_pkg::CH_NL) begin
                        do_eol = 1'b1;
                    end else begin
                        tmp.result_kind = elcs_pkg::KIND_COMMENT;
                        tmp.byte_value  = c;
                        res[cnt[0]]     = tmp;
                        cnt             = cnt + 2'd1;
                    end
                end
                elcs_pkg::MODE_BSL: begin
                    n_mode = elcs_pkg::MODE_NORMAL;
                    if (esc.hit) begin
                        tmp.byte_value = esc.value;
                        res[cnt[0]]    = tmp;
                        cnt            = cnt + 2'd1;
                        n_has_bytes    = 1'b1;
                    end else if (c == elcs_pkg::CH_SPACE || c == elcs_pkg::CH_TAB) begin
                        n_mode = elcs_pkg::MODE_CONT;
                    end else if (c == elcs_pkg::CH_NL) begin
                        n_lines_consumed = r_lines_consumed + LNB'(1);
                    end else if (is_oct) begin
                        n_mode       = elcs_pkg::MODE_OCT;
                        n_oct_val    = {6'd0, c[2:0]};
                        n_oct_digits = 2'd1;
                    end else begin
                        // unknown escape passes through flagged
                        tmp.byte_value = c;
                        tmp.bad_escape = 1'b1;
                        res[cnt[0]]    = tmp;
                        cnt            = cnt + 2'd1;
                        n_has_bytes    = 1'b1;
                    end
                end
                default: begin
                    n_mode = elcs_pkg::MODE_NORMAL;
                    if (c == elcs_pkg::CH_BACKSLASH) begin
                        n_mode = elcs_pkg::MODE_BSL;
                    end else if (c == elcs_pkg::CH_HASH) begin
                        n_mode = elcs_pkg::MODE_COMLEAD;
                    end else if (c == elcs_pkg::CH_NL) begin
                        do_eol = 1'b1;
                    end else begin
                        tmp.byte_value = c;
                        res[cnt[0]]    = tmp;
                        cnt            = cnt + 2'd1;
                        n_has_bytes    = 1'b1;
                    end
                end
            endcase

            // end of logical line
            if (do_eol) begin
                tmp.result_kind  = elcs_pkg::KIND_EOL;
                tmp.byte_value   = 8'd0;
                res[cnt[0]]      = tmp;
                cnt              = cnt + 2'd1;
                n_line_start     = w_adv_eol;
                n_lines_consumed = '0;
                n_has_bytes      = 1'b0;
                n_mode           = elcs_pkg::MODE_NORMAL;
            end
        end

        // mark the last word of the item
        res[0].last_result = (cnt == 2'd1);
        res[1].last_result = (cnt == 2'd2);

        o_push.count = w_go ? cnt : 2'd0;
        o_push.res0  = res[0];
        o_push.res1  = res[1];
    end

    // parser state; a register write reloads the line counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= elcs_pkg::MODE_NORMAL;
            r_oct_val        <= 9'd0;
            r_oct_digits     <= 2'd0;
            r_line_start     <= w_rst_ext[LNB-1:0];
            r_lines_consumed <= '0;
            r_has_bytes      <= 1'b0;
        end else begin
            if (w_go) begin
                r_mode           <= n_mode;
                r_oct_val        <= n_oct_val;
                r_oct_digits     <= n_oct_digits;
                r_line_start     <= n_line_start;
                r_lines_consumed <= n_lines_consumed;
                r_has_bytes      <= n_has_bytes;
            end
            if (i_cfg.wr) begin
                r_line_start     <= w_cfg_ext[LNB-1:0];
                r_lines_consumed <= '0;
            end
        end
    end

endmodule

// ===== src/elcs_out_queue.sv =====
// three-word result queue taking up to two words per cycle
// depends on elcs_pkg
module elcs_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  elcs_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output elcs_pkg::t_out_word o_word
);

    localparam int DEPTH = 3;

    elcs_pkg::t_out_word r_mem [DEPTH];
    logic [1:0]          r_wr_ptr, r_rd_ptr, r_count;
    logic [1:0]          w_wr_ptr1;
    logic                w_pop;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign w_wr_ptr1 = ptr_inc(r_wr_ptr);
    assign o_valid   = (r_count != 2'd0);
    assign o_word    = r_mem[r_rd_ptr];
    assign w_pop     = o_valid && i_ready;
    assign o_room    = (r_count <= 2'd1);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.count == 2'd1) begin
                r_wr_ptr <= w_wr_ptr1;
            end else if (i_push.count == 2'd2) begin
                r_wr_ptr <= ptr_inc(w_wr_ptr1);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + i_push.count - {1'b0, w_pop};
        end
    end

endmodule

// ===== src/elcs_checker.sv =====
// port-level checks on the result stream and the register port, bound to the top level
// depends on elcs_pkg and assert_macros.svh
`include "assert_macros.svh"

module elcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input elcs_pkg::t_out_word i_out_word,
    input logic                i_pready
);

    logic w_eoi;
    logic w_eol;

    assign w_eoi = i_out_valid && (i_out_word.result_kind == elcs_pkg::KIND_EOI);
    assign w_eol = i_out_valid && (i_out_word.result_kind == elcs_pkg::KIND_EOL);

    // stalled word holds
    `ELCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word))
    // end of input always closes its item
    `ELCS_ASSERT_IMPLY(a_eoi_last, i_clk, i_rst_n, w_eoi, i_out_word.last_result && i_out_word.byte_value == 8'd0)
    // end-of-line markers carry no byte and no flags
    `ELCS_ASSERT_IMPLY(a_eol_clean, i_clk, i_rst_n, w_eol, i_out_word.byte_value == 8'd0 && !i_out_word.bad_escape && !i_out_word.truncated_line && i_out_word.last_result)
    // bad escape only on a line byte
    `ELCS_ASSERT_IMPLY(a_bad_kind, i_clk, i_rst_n, i_out_valid && i_out_word.bad_escape, i_out_word.result_kind == elcs_pkg::KIND_LINE)
    // register port never waits
    `ELCS_ASSERT_IMPLY(a_pready, i_clk, i_rst_n, 1'b1, i_pready)

endmodule

bind escaped_line_comment_splitter_top elcs_checker u_elcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_word  (o_result.payload),
    .i_pready    (pready)
);

// ===== sim/line_lexer_checker.sv =====
// checker of the line lexer: follows accepted bytes and register writes,
// predicts every result word and compares it with the word the block delivers
// depends on elcs_pkg and elcs_stream_if
module line_lexer_checker
    import elcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    elcs_stream_if                   i_text,
    elcs_stream_if                   i_result,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [APB_ADDR_BITS-1:0] i_paddr,
    input  logic [APB_DATA_BITS-1:0] i_pwdata,
    input  logic                     i_pready,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam logic [APB_ADDR_BITS-1:0] FIRST_LINE_ADDR = {REG_FIRST_LINE, 2'b00};

    // predictor state
    t_mode       mode;
    logic [8:0]  oct_val;
    logic [1:0]  oct_cnt;
    logic [23:0] first_line;
    logic [23:0] line_start;
    logic [23:0] lines_used;
    logic        has_bytes;

    // words of the byte being lexed, then the queue of all words still due
    t_out_word   step_words [2];
    int          step_n;
    t_out_word   expected_words [$];

    int          fail_total = 0;
    int          words_checked = 0;

    assign o_fail_count = fail_total;

    function automatic void reset_model();
        mode       = MODE_NORMAL;
        oct_val    = '0;
        oct_cnt    = '0;
        first_line = FIRST_LINE_RESET;
        line_start = FIRST_LINE_RESET;
        lines_used = '0;
        has_bytes  = 1'b0;
        expected_words.delete();
    endfunction

    function automatic void put_word(t_kind kind, logic [7:0] value, logic bad, logic trunc);
        t_out_word w;
        w.result_kind      = kind;
        w.byte_value       = value;
        w.line_number      = line_start;
        w.bad_escape       = bad;
        w.truncated_line   = trunc;
        w.last_result      = 1'b0;
        step_words[step_n] = w;
        step_n++;
    endfunction

    function automatic void put_line_byte(logic [7:0] value, logic bad);
        has_bytes = 1'b1;
        put_word(KIND_LINE, value, bad, 1'b0);
    endfunction

    // next logical line starts after all physical lines eaten so far
    function automatic void advance_lines();
        line_start = line_start + lines_used;
        lines_used = '0;
        has_bytes  = 1'b0;
    endfunction

    function automatic void close_line();
        put_word(KIND_EOL, 8'h00, 1'b0, 1'b0);
        lines_used = lines_used + 24'd1;
        advance_lines();
        mode = MODE_NORMAL;
    endfunction

    function automatic logic is_octal(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    function automatic void clear_octal();
        mode    = MODE_NORMAL;
        oct_val = '0;
        oct_cnt = '0;
    endfunction

    // byte right after a backslash
    function automatic void decode_escape(logic [7:0] c);
        mode = MODE_NORMAL;
        case (c)
            CH_B:         put_line_byte(8'd8, 1'b0);
            CH_BACKSLASH: put_line_byte(CH_BACKSLASH, 1'b0);
            CH_P:         put_line_byte(CH_HASH, 1'b0);
            CH_F:         put_line_byte(8'd12, 1'b0);
            CH_A:         put_line_byte(8'd7, 1'b0);
            CH_R:         put_line_byte(8'd13, 1'b0);
            CH_T:         put_line_byte(8'd9, 1'b0);
            CH_N:         put_line_byte(8'd10, 1'b0);
            CH_SPACE, CH_TAB: mode = MODE_CONT;
            CH_NL:        lines_used = lines_used + 24'd1;
            default: begin
                if (is_octal(c)) begin
                    mode    = MODE_OCT;
                    oct_val = {6'd0, c[2:0]};
                    oct_cnt = 2'd1;
                end else begin
                    // unknown escape passes through flagged
                    put_line_byte(c, 1'b1);
                end
            end
        endcase
    endfunction

    // predicted words of one accepted input word
    function automatic void lex_word(t_in_word w);
        logic [7:0] c;
        logic       done;
        t_out_word  r;
        c      = w.text_byte;
        done   = 1'b0;
        step_n = 0;
        if (w.end_of_input) begin
            // pending escape, octal or comment is dropped
            put_word(KIND_EOI, 8'h00, 1'b0, has_bytes);
            clear_octal();
            advance_lines();
            done = 1'b1;
        end else if (mode == MODE_OCT) begin
            if (is_octal(c)) begin
                oct_val = {oct_val[5:0], c[2:0]};
                oct_cnt = oct_cnt + 2'd1;
                if (oct_cnt == OCT_MAX_DIGITS) begin
                    put_line_byte(oct_val[7:0], 1'b0);
                    clear_octal();
                end
                done = 1'b1;
            end else begin
                // octal cut short: its byte goes out ahead of this one
                put_line_byte(oct_val[7:0], 1'b0);
                clear_octal();
            end
        end
        if (!done) begin
            case (mode)
                MODE_CONT: begin
                    if (c == CH_NL) begin
                        lines_used = lines_used + 24'd1;
                        mode       = MODE_NORMAL;
                    end
                end
                MODE_COMLEAD: begin
                    if (c == CH_NL) begin
                        close_line();
                    end else if (c != CH_SPACE && c != CH_TAB) begin
                        mode = MODE_COMBODY;
                        put_word(KIND_COMMENT, c, 1'b0, 1'b0);
                    end
                end
                MODE_COMBODY: begin
                    if (c == CH_NL) close_line();
                    else put_word(KIND_COMMENT, c, 1'b0, 1'b0);
                end
                MODE_BSL: decode_escape(c);
                default: begin
                    mode = MODE_NORMAL;
                    if (c == CH_BACKSLASH) mode = MODE_BSL;
                    else if (c == CH_HASH) mode = MODE_COMLEAD;
                    else if (c == CH_NL) close_line();
                    else put_line_byte(c, 1'b0);
                end
            endcase
        end
        for (int i = 0; i < step_n; i++) begin
            r             = step_words[i];
            r.last_result = (i == step_n - 1);
            expected_words.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] result word %0d: %s", $time, words_checked, what);
        fail_total++;
    endtask

    task automatic check_field(string field, logic [23:0] got, logic [23:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    task automatic check_word(t_out_word got);
        t_out_word want;
        if (expected_words.size() == 0) begin
            report_mismatch("word arrived with nothing expected");
        end else begin
            want = expected_words.pop_front();
            check_field("result_kind", got.result_kind, want.result_kind);
            check_field("byte_value", got.byte_value, want.byte_value);
            check_field("line_number", got.line_number, want.line_number);
            check_field("bad_escape", got.bad_escape, want.bad_escape);
            check_field("truncated_line", got.truncated_line, want.truncated_line);
            check_field("last_result", got.last_result, want.last_result);
        end
        words_checked++;
    endtask

    // watch register writes, accepted bytes and delivered words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == FIRST_LINE_ADDR) begin
                first_line = i_pwdata[23:0];
                line_start = i_pwdata[23:0];
                lines_used = '0;
            end
            if (i_text.valid && i_text.ready) lex_word(i_text.payload);
            if (i_result.valid && i_result.ready) check_word(i_result.payload);
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench top of the line lexer: clock, reset, byte stimulus, register
// writes and the verdict; prediction and checking sit in line_lexer_checker
// depends on elcs_pkg, elcs_stream_if and escaped_line_comment_splitter_top
module tb_top;
    import elcs_pkg::*;

    localparam logic [APB_ADDR_BITS-1:0] FIRST_LINE_ADDR = {REG_FIRST_LINE, 2'b00};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int chk_fail_count;
    int chk_pending;
    int tx_idle_pct = 9;
    int rx_idle_pct = 49;
    int bytes_sent  = 0;

    logic [7:0] esc_letters [8] = '{CH_B, CH_BACKSLASH, CH_P, CH_F, CH_A, CH_R, CH_T, CH_N};

    elcs_stream_if #(.t_payload(t_in_word))  text_ch ();
    elcs_stream_if #(.t_payload(t_out_word)) result_ch ();

    escaped_line_comment_splitter_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_text   (text_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    line_lexer_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_text       (text_ch),
        .i_result     (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    always #5 clk = ~clk;

    // hard stop in case the run hangs
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: ready drops at random at the current idle rate
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one word, with random gaps ahead, and wait until it is taken
    task automatic send_word(logic [7:0] value, logic eoi);
        t_in_word w;
        w.text_byte    = value;
        w.end_of_input = eoi;
        while ($urandom_range(99) < tx_idle_pct) begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.payload <= w;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_byte(logic [7:0] value);
        send_word(value, 1'b0);
    endtask

    task automatic send_end(logic [7:0] value);
        send_word(value, 1'b1);
    endtask

    // stop sending until every predicted word is back, plus a latency margin
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_register(logic [APB_ADDR_BITS-1:0] addr,
                                  logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // printable byte that is neither a backslash nor a hash
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(126, 32));
        if (b == CH_BACKSLASH || b == CH_HASH) b = b + 8'd1;
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    // one random piece of text, mostly well formed
    task automatic send_piece();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30) begin
            n = $urandom_range(6, 1);
            repeat (n) send_byte(plain_byte());
        end else if (pick < 42) begin
            send_byte(CH_NL);
        end else if (pick < 54) begin
            send_byte(CH_BACKSLASH);
            send_byte(esc_letters[$urandom_range(7)]);
        end else if (pick < 64) begin
            // fewer than three digits end on the next byte
            send_byte(CH_BACKSLASH);
            n = $urandom_range(3, 1);
            repeat (n) send_byte(8'($urandom_range(CH_SEVEN, CH_ZERO)));
        end else if (pick < 70) begin
            send_byte(CH_BACKSLASH);
            send_byte(8'($urandom_range(255)));
        end else if (pick < 78) begin
            // continuation: backslash newline, or backslash blank junk newline
            send_byte(CH_BACKSLASH);
            if ($urandom_range(1)) begin
                send_byte(blank_byte());
                n = $urandom_range(3);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
            send_byte(CH_NL);
        end else if (pick < 90) begin
            send_byte(CH_HASH);
            n = $urandom_range(3);
            repeat (n) send_byte(blank_byte());
            n = $urandom_range(5);
            repeat (n) send_byte($urandom_range(3) == 0 ? 8'($urandom_range(255)) : plain_byte());
            send_byte(CH_NL);
        end else if (pick < 95) begin
            n = $urandom_range(3, 1);
            repeat (n) send_byte(8'($urandom_range(255)));
        end else if (pick < 98) begin
            send_end(8'($urandom_range(255)));
        end else begin
            // escape or comment start cut off by the end of input
            send_byte($urandom_range(1) ? CH_BACKSLASH : CH_HASH);
            send_end(8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(int target);
        while (bytes_sent < target) send_piece();
    endtask

    // main sequence
    initial begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        text_ch.valid   <= 1'b0;
        text_ch.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end of input on an empty line
        send_end(8'h00);
        // zero and all-ones bytes, comment with leading blanks
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_HASH);
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte(8'h63);
        send_byte(CH_NL);
        // three-digit octal over 8 bits
        send_byte(CH_BACKSLASH);
        repeat (3) send_byte(CH_SEVEN);
        // two-digit octal ended by a plain byte
        send_byte(CH_BACKSLASH);
        send_byte(8'h31);
        send_byte(8'h32);
        send_byte(CH_P);
        // unknown escape
        send_byte(CH_BACKSLASH);
        send_byte(8'h71);
        // backslash newline
        send_byte(CH_BACKSLASH);
        send_byte(CH_NL);
        // backslash blank eats up to the newline
        send_byte(CH_BACKSLASH);
        send_byte(CH_SPACE);
        send_byte(CH_HASH);
        send_byte(CH_NL);
        // escaped hash, then end of input on an unfinished line
        send_byte(CH_BACKSLASH);
        send_byte(CH_P);
        send_end(8'hA5);

        // line numbers at the top of the range
        wait_drained();
        write_register(FIRST_LINE_ADDR, 32'h00FF_FFFF);
        run_random(475);

        wait_drained();
        write_register(FIRST_LINE_ADDR, 32'h0000_0000);
        tx_idle_pct = 49;
        rx_idle_pct = 9;
        run_random(925);

        wait_drained();
        write_register(FIRST_LINE_ADDR, $urandom());
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(1150);
        wait_drained();
        run_random(1375);

        wait_drained();
        if (chk_fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
